FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while in reset
`define SIP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed: %m");

// clocked assertion, also checked during reset
`define SIP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed: %m");

`endif

FILE: rtl/core/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Widths, types and the scaling step of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int CoordW  = 32;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int NumW    = ProdW + 1;
  localparam int MagW    = ProdW;
  localparam int AccW    = MagW + 2;
  localparam int Stages  = CoordW;
  localparam int Latency = 5 + Stages + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [CoordW-1:0] ucoord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [NumW-1:0]   num_t;
  typedef logic        [MagW-1:0]   mag_t;
  typedef logic        [AccW-1:0]   acc_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    diff_t  ex;
    diff_t  ey;
    num_t   den;
    num_t   rn;
    num_t   sn;
  } front_t;

  typedef struct packed {
    logic    hit;
    coord_t  ax;
    coord_t  ay;
    logic    nx;
    logic    ny;
    ucoord_t mx;
    ucoord_t my;
    mag_t    den;
    mag_t    rn;
  } norm_t;

  typedef struct packed {
    logic    hit;
    coord_t  ax;
    coord_t  ay;
    logic    nx;
    logic    ny;
    ucoord_t mx;
    ucoord_t my;
    mag_t    rx;
    mag_t    ry;
    ucoord_t qx;
    ucoord_t qy;
    mag_t    den;
    mag_t    rn;
  } lane_t;

  typedef struct packed {
    mag_t       r;
    logic [1:0] d;
  } step_t;

  // one digit of floor(rn*m/den): r' = 2r + b*rn reduced by up to two den
  function automatic step_t scale_step(mag_t r, logic b, mag_t rn, mag_t den);
    acc_t  v0;
    acc_t  v1;
    acc_t  v2;
    step_t s;
    v0 = {1'b0, r, 1'b0} + (b ? {2'b00, rn} : '0);
    v1 = {1'b0, r, 1'b0} + (b ? {2'b00, rn} : '0) - {2'b00, den};
    v2 = {1'b0, r, 1'b0} + (b ? {2'b00, rn} : '0) - {1'b0, den, 1'b0};
    if (!v2[AccW-1]) begin
      s.r = v2[MagW-1:0];
      s.d = 2'd2;
    end else if (!v1[AccW-1]) begin
      s.r = v1[MagW-1:0];
      s.d = 2'd1;
    end else begin
      s.r = v0[MagW-1:0];
      s.d = 2'd0;
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// segment_intersection_point
// Intersection point of two 2-D segments, signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// command   in         start_i / busy_o   a_x_i .. d_y_i
// result    out        done_o strobe      hit_o, cross_x_o, cross_y_o
//
// One transaction enters every cycle; busy_o is always low.
// The stages are 3 front stages (differences, products, den/rn/sn),
// 2 normalize/test stages, 32 divider stages (one quotient digit each), 1 output.
// Reset clears only the valid bits and hit_q; the result side cannot stall.
// ----------------------------------------------------------------------------
module segment_intersection_point (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  sip_pkg::coord_t a_x_i,
  input  sip_pkg::coord_t a_y_i,
  input  sip_pkg::coord_t b_x_i,
  input  sip_pkg::coord_t b_y_i,
  input  sip_pkg::coord_t c_x_i,
  input  sip_pkg::coord_t c_y_i,
  input  sip_pkg::coord_t d_x_i,
  input  sip_pkg::coord_t d_y_i,
  output logic            done_o,
  output logic            hit_o,
  output sip_pkg::coord_t cross_x_o,
  output sip_pkg::coord_t cross_y_o
);
  import sip_pkg::*;

  logic   front_vld, norm_vld, lane_vld;
  front_t front;
  norm_t  norm;
  lane_t  lane;
  logic   done_q, hit_q;
  coord_t cx_q, cy_q;
  coord_t px, py;

  assign busy_o = 1'b0;

  sip_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .c_x_i   (c_x_i),
    .c_y_i   (c_y_i),
    .d_x_i   (d_x_i),
    .d_y_i   (d_y_i),
    .valid_o (front_vld),
    .front_o (front)
  );

  sip_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .front_i (front),
    .valid_o (norm_vld),
    .norm_o  (norm)
  );

  sip_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_vld),
    .norm_i  (norm),
    .valid_o (lane_vld),
    .lane_o  (lane)
  );

  assign px = lane.nx ? lane.ax - coord_t'(lane.qx) : lane.ax + coord_t'(lane.qx);
  assign py = lane.ny ? lane.ay - coord_t'(lane.qy) : lane.ay + coord_t'(lane.qy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      done_q <= lane_vld;
      hit_q  <= lane_vld & lane.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= lane.hit ? px : '0;
    cy_q <= lane.hit ? py : '0;
  end

  assign done_o    = done_q;
  assign hit_o     = hit_q;
  assign cross_x_o = cx_q;
  assign cross_y_o = cy_q;

endmodule

FILE: rtl/core/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// Edge vectors, the six cross products and den/rn/sn, three stages.
// ----------------------------------------------------------------------------
module sip_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sip_pkg::coord_t a_x_i,
  input  sip_pkg::coord_t a_y_i,
  input  sip_pkg::coord_t b_x_i,
  input  sip_pkg::coord_t b_y_i,
  input  sip_pkg::coord_t c_x_i,
  input  sip_pkg::coord_t c_y_i,
  input  sip_pkg::coord_t d_x_i,
  input  sip_pkg::coord_t d_y_i,
  output logic            valid_o,
  output sip_pkg::front_t front_o
);
  import sip_pkg::*;

  logic   v1_q, v2_q, v3_q;
  coord_t ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  diff_t  ex1_q, ey1_q, fx1_q, fy1_q, gx1_q, gy1_q;
  diff_t  ex2_q, ey2_q, ex3_q, ey3_q;
  prod_t  p_efy_q, p_eyf_q, p_fyg_q, p_fxg_q, p_eyg_q, p_exg_q;
  num_t   den_q, rn_q, sn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q <= a_x_i;
    ay1_q <= a_y_i;
    ex1_q <= diff_t'(b_x_i) - diff_t'(a_x_i);
    ey1_q <= diff_t'(b_y_i) - diff_t'(a_y_i);
    fx1_q <= diff_t'(d_x_i) - diff_t'(c_x_i);
    fy1_q <= diff_t'(d_y_i) - diff_t'(c_y_i);
    gx1_q <= diff_t'(c_x_i) - diff_t'(a_x_i);
    gy1_q <= diff_t'(c_y_i) - diff_t'(a_y_i);

    ax2_q   <= ax1_q;
    ay2_q   <= ay1_q;
    ex2_q   <= ex1_q;
    ey2_q   <= ey1_q;
    p_efy_q <= prod_t'(ex1_q) * prod_t'(fy1_q);
    p_eyf_q <= prod_t'(ey1_q) * prod_t'(fx1_q);
    p_fyg_q <= prod_t'(fy1_q) * prod_t'(gx1_q);
    p_fxg_q <= prod_t'(fx1_q) * prod_t'(gy1_q);
    p_eyg_q <= prod_t'(ey1_q) * prod_t'(gx1_q);
    p_exg_q <= prod_t'(ex1_q) * prod_t'(gy1_q);

    ax3_q <= ax2_q;
    ay3_q <= ay2_q;
    ex3_q <= ex2_q;
    ey3_q <= ey2_q;
    den_q <= num_t'(p_efy_q) - num_t'(p_eyf_q);
    rn_q  <= num_t'(p_fyg_q) - num_t'(p_fxg_q);
    sn_q  <= num_t'(p_eyg_q) - num_t'(p_exg_q);
  end

  assign valid_o     = v3_q;
  assign front_o.ax  = ax3_q;
  assign front_o.ay  = ay3_q;
  assign front_o.ex  = ex3_q;
  assign front_o.ey  = ey3_q;
  assign front_o.den = den_q;
  assign front_o.rn  = rn_q;
  assign front_o.sn  = sn_q;

endmodule

FILE: rtl/core/sip_norm.sv
// ----------------------------------------------------------------------------
// sip_norm
// Sign normalization against den and the closed range tests, two stages.
// ----------------------------------------------------------------------------
module sip_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sip_pkg::front_t front_i,
  output logic            valid_o,
  output sip_pkg::norm_t  norm_o
);
  import sip_pkg::*;

  logic   v4_q, v5_q;
  coord_t ax4_q, ay4_q;
  diff_t  ex4_q, ey4_q;
  logic   nz4_q;
  num_t   den4_q, rn4_q, sn4_q;
  norm_t  norm_q;
  logic   neg;

  assign neg = front_i.den[NumW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax4_q  <= front_i.ax;
    ay4_q  <= front_i.ay;
    ex4_q  <= front_i.ex;
    ey4_q  <= front_i.ey;
    nz4_q  <= |front_i.den;
    den4_q <= neg ? -front_i.den : front_i.den;
    rn4_q  <= neg ? -front_i.rn : front_i.rn;
    sn4_q  <= neg ? -front_i.sn : front_i.sn;

    norm_q.hit <= nz4_q && !rn4_q[NumW-1] && !sn4_q[NumW-1]
                  && (rn4_q <= den4_q) && (sn4_q <= den4_q);
    norm_q.ax  <= ax4_q;
    norm_q.ay  <= ay4_q;
    norm_q.nx  <= ex4_q[DiffW-1];
    norm_q.ny  <= ey4_q[DiffW-1];
    norm_q.mx  <= ex4_q[DiffW-1] ? ucoord_t'(-ex4_q) : ucoord_t'(ex4_q);
    norm_q.my  <= ey4_q[DiffW-1] ? ucoord_t'(-ey4_q) : ucoord_t'(ey4_q);
    norm_q.den <= den4_q[MagW-1:0];
    norm_q.rn  <= rn4_q[MagW-1:0];
  end

  assign valid_o = v5_q;
  assign norm_o  = norm_q;

endmodule

FILE: rtl/core/sip_scale.sv
// ----------------------------------------------------------------------------
// sip_scale
// Pipelined floor(rn*|E|/den) for both axes, one quotient digit per stage.
// ----------------------------------------------------------------------------
module sip_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sip_pkg::norm_t norm_i,
  output logic           valid_o,
  output sip_pkg::lane_t lane_o
);
  import sip_pkg::*;

  logic  vld_q  [Stages];
  lane_t lane_q [Stages];
  logic  vld_in [Stages];
  lane_t lane_in[Stages];

  always_comb begin
    vld_in[0]      = valid_i;
    lane_in[0].hit = norm_i.hit;
    lane_in[0].ax  = norm_i.ax;
    lane_in[0].ay  = norm_i.ay;
    lane_in[0].nx  = norm_i.nx;
    lane_in[0].ny  = norm_i.ny;
    lane_in[0].mx  = norm_i.mx;
    lane_in[0].my  = norm_i.my;
    lane_in[0].rx  = '0;
    lane_in[0].ry  = '0;
    lane_in[0].qx  = '0;
    lane_in[0].qy  = '0;
    lane_in[0].den = norm_i.den;
    lane_in[0].rn  = norm_i.rn;
    for (int k = 1; k < Stages; k++) begin
      vld_in[k]  = vld_q[k-1];
      lane_in[k] = lane_q[k-1];
    end
  end

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    step_t sx, sy;

    assign sx = scale_step(lane_in[k].rx, lane_in[k].mx[CoordW-1],
                           lane_in[k].rn, lane_in[k].den);
    assign sy = scale_step(lane_in[k].ry, lane_in[k].my[CoordW-1],
                           lane_in[k].rn, lane_in[k].den);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      lane_q[k].hit <= lane_in[k].hit;
      lane_q[k].ax  <= lane_in[k].ax;
      lane_q[k].ay  <= lane_in[k].ay;
      lane_q[k].nx  <= lane_in[k].nx;
      lane_q[k].ny  <= lane_in[k].ny;
      lane_q[k].mx  <= lane_in[k].mx << 1;
      lane_q[k].my  <= lane_in[k].my << 1;
      lane_q[k].rx  <= sx.r;
      lane_q[k].ry  <= sy.r;
      lane_q[k].qx  <= (lane_in[k].qx << 1) + ucoord_t'(sx.d);
      lane_q[k].qy  <= (lane_in[k].qy << 1) + ucoord_t'(sy.d);
      lane_q[k].den <= lane_in[k].den;
      lane_q[k].rn  <= lane_in[k].rn;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign lane_o  = lane_q[Stages-1];

endmodule

FILE: rtl/core/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks of the segment intersection block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sip_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic            done_o,
  input logic            hit_o,
  input sip_pkg::coord_t cross_x_o,
  input sip_pkg::coord_t cross_y_o
);
  import sip_pkg::*;

  `SIP_ASSERT_ALWAYS(a_never_busy, !busy_o)
  `SIP_ASSERT(a_hit_needs_done, hit_o |-> done_o)
  `SIP_ASSERT(a_miss_zero, (done_o && !hit_o) |-> (cross_x_o == '0 && cross_y_o == '0))
  `SIP_ASSERT(a_done_after_start,
    (done_o && $past(rst_ni, Latency)) |-> $past(start_i, Latency))

endmodule

bind segment_intersection_point sip_checker u_sip_checker (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_intersection_point. A directed table covers
// the zero, parallel, disjoint, crossing, endpoint and full-scale cases.
// Random segment pairs follow: small-range, full-range and crossing shapes.
// Every result strobe is compared with a typed point or an intersection predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sip_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic   hit;
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct {
    coord_t c[8];
    logic   typed;
    point_t pt;
  } stim_row_t;

  localparam int NumRandom  = 1900;
  localparam int IdleLimit  = 2000;
  localparam coord_t Max    = 32'sh7fffffff;
  localparam coord_t Min    = 32'sh80000000;
  localparam coord_t One    = 32'sh00010000;
  localparam coord_t Two    = 32'sh00020000;
  localparam coord_t NegOne = -32'sh00010000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   busy_o;
  coord_t crd [8];
  logic   done_o;
  logic   hit_o;
  coord_t cross_x_o;
  coord_t cross_y_o;

  point_t pending_points[$];
  int     n_mismatch = 0;
  int     idle_cycles = 0;
  int     sender_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  initial for (int i = 0; i < 8; i++) crd[i] = '0;

  segment_intersection_point u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .a_x_i     (crd[0]),
    .a_y_i     (crd[1]),
    .b_x_i     (crd[2]),
    .b_y_i     (crd[3]),
    .c_x_i     (crd[4]),
    .c_y_i     (crd[5]),
    .d_x_i     (crd[6]),
    .d_y_i     (crd[7]),
    .done_o    (done_o),
    .hit_o     (hit_o),
    .cross_x_o (cross_x_o),
    .cross_y_o (cross_y_o)
  );

  function automatic wide_t widen(coord_t v);
    wide_t w;
    w = v;
    return w;
  endfunction

  function automatic coord_t place_on_ab(coord_t base, wide_t delta, wide_t rn, wide_t den);
    wide_t mag;
    wide_t q;
    wide_t p;
    mag = (delta < 0) ? -delta : delta;
    q   = (rn * mag) / den;
    p   = (delta < 0) ? widen(base) - q : widen(base) + q;
    return p[31:0];
  endfunction

  function automatic point_t intersect_point(coord_t c[8]);
    wide_t  ex, ey, fx, fy, gx, gy, den, rn, sn;
    point_t pt;
    ex  = widen(c[2]) - widen(c[0]);
    ey  = widen(c[3]) - widen(c[1]);
    fx  = widen(c[6]) - widen(c[4]);
    fy  = widen(c[7]) - widen(c[5]);
    gx  = widen(c[4]) - widen(c[0]);
    gy  = widen(c[5]) - widen(c[1]);
    den = ex * fy - ey * fx;
    rn  = fy * gx - fx * gy;
    sn  = ey * gx - ex * gy;
    pt  = '{1'b0, '0, '0};
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        rn  = -rn;
        sn  = -sn;
      end
      if (rn >= 0 && rn <= den && sn >= 0 && sn <= den) begin
        pt.hit = 1'b1;
        pt.x   = place_on_ab(c[0], ex, rn, den);
        pt.y   = place_on_ab(c[1], ey, rn, den);
      end
    end
    return pt;
  endfunction

  task automatic send_segments(coord_t c[8], logic typed, point_t typed_pt);
    logic   was_busy;
    point_t exp_pt;
    while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    for (int i = 0; i < 8; i++) crd[i] <= c[i];
    do begin
      @(negedge clk_i);
      was_busy = busy_o;
      @(posedge clk_i);
    end while (was_busy);
    exp_pt = typed ? typed_pt : intersect_point(c);
    pending_points = {pending_points, exp_pt};
  endtask

  function automatic coord_t small_coord(int span);
    return coord_t'($urandom_range(2 * span, 0)) - coord_t'(span);
  endfunction

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_points.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result: hit=%0b x=%h y=%h", hit_o, cross_x_o, cross_y_o);
        end else begin
          want = pending_points.pop_front();
          if (hit_o !== want.hit || cross_x_o !== want.x || cross_y_o !== want.y) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: exp hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
                       want.hit, want.x, want.y, hit_o, cross_x_o, cross_y_o);
          end
        end
      end
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t dir_tbl[] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b0, 0, 0}},
      '{'{0, 0, Two, 0, 0, One, Two, One}, 1'b1, '{1'b0, 0, 0}},
      '{'{0, 0, One, 0, Two, NegOne, Two, One}, 1'b1, '{1'b0, 0, 0}},
      '{'{NegOne, 0, One, 0, 0, NegOne, 0, One}, 1'b1, '{1'b1, 0, 0}},
      '{'{0, 0, Two, 0, Two, NegOne, Two, One}, 1'b1, '{1'b1, Two, 0}},
      '{'{0, 0, Two, 0, 0, 0, 0, One}, 1'b1, '{1'b1, 0, 0}},
      '{'{0, 0, Two, 0, One, 0, Max, 0}, 1'b1, '{1'b0, 0, 0}},
      '{'{Min, Min, Max, Max, Min, Max, Max, Min}, 1'b0, '{1'b0, 0, 0}},
      '{'{Max, Min, Min, Max, Min, Min, Max, Max}, 1'b0, '{1'b0, 0, 0}},
      '{'{Min, 0, Max, 0, 0, Min, 0, Max}, 1'b0, '{1'b0, 0, 0}},
      '{'{Max, Max, Max, Max, Min, Min, Min, Min}, 1'b1, '{1'b0, 0, 0}},
      '{'{Min, Min, Max, Min, Max, Min, Max, Max}, 1'b0, '{1'b0, 0, 0}},
      '{'{-3, 7, 11, -5, 2, -9, 4, 13}, 1'b0, '{1'b0, 0, 0}},
      '{'{Min, Max, Min, Min, Max, 0, Min, 1}, 1'b0, '{1'b0, 0, 0}}
    };
    coord_t c[8];
    coord_t k;
    point_t none;
    none = '{1'b0, 0, 0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 31;
    foreach (dir_tbl[i]) send_segments(dir_tbl[i].c, dir_tbl[i].typed, dir_tbl[i].pt);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) sender_idle_pct = 56;
      if (n == 2 * NumRandom / 3) sender_idle_pct = 0;
      case ($urandom_range(9, 0))
        0, 1, 2: begin
          for (int i = 0; i < 8; i++) c[i] = $urandom;
        end
        3, 4: begin
          for (int i = 0; i < 8; i++) c[i] = small_coord(1000);
        end
        default: begin
          k    = coord_t'($urandom_range(32'h7fff_0000, 1));
          c[0] = -k;
          c[1] = small_coord(int'(k >>> 1));
          c[2] = k;
          c[3] = small_coord(int'(k >>> 1));
          c[4] = small_coord(int'(k >>> 1));
          c[5] = -k;
          c[6] = small_coord(int'(k >>> 1));
          c[7] = k;
        end
      endcase
      send_segments(c, 1'b0, none);
    end
    start_i <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sip_pkg.sv
rtl/core/sip_front.sv
rtl/core/sip_norm.sv
rtl/core/sip_scale.sv
rtl/core/segment_intersection_point.sv
rtl/core/sip_checker.sv
bench/tb_top.sv
